// ===== hw/rtl/atu_pkg.sv =====
package atu_pkg;

  localparam int SINE_DEPTH   = 91;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = HALF_TURN / 2;
  localparam int FULL_TURN    = 2 * HALF_TURN;
  localparam int ACC_W        = 66;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    FN_TRANSLATE, FN_ROTATE, FN_ROTATE_REF, FN_SCALE, FN_SCALE_REF,
    FN_REFLECT_X, FN_REFLECT_Y, FN_REFLECT_YX, FN_REFLECT_YNX,
    FN_SHEAR_X, FN_SHEAR_Y, FN_XFORM, FN_RESET
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BUILD, S_COMP, S_WAIT, S_XFORM, S_DRAIN1, S_DRAIN2
  } state_t;

  typedef enum logic [2:0] {A_C, A_S, A_PX, A_PY, A_MA, A_MB} a_sel_t;
  typedef enum logic [3:0] {
    B_CX, B_CY, B_E0, B_E1, B_E2, B_E3, B_E4, B_E5, B_QX, B_QY
  } b_sel_t;
  typedef enum logic [1:0] {ADD_NONE, ADD_CX, ADD_CY, ADD_MT} add_sel_t;
  typedef enum logic [2:0] {
    WR_NONE, WR_E2, WR_E5, WR_NB0, WR_NB1, WR_ROW, WR_OX, WR_OY
  } wr_sel_t;

  typedef struct packed {
    logic     load;
    logic     issue;
    a_sel_t   a_sel;
    b_sel_t   b_sel;
    add_sel_t add_sel;
    wr_sel_t  wr_sel;
    logic     row;
    logic     neg;
    logic     clr;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               hit;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] x);
    sat_t r;
    r.hit = !((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31]));
    if (r.hit) r.v = x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r.v = x[31:0];
    return r;
  endfunction

  function automatic logic [63:0] taylor_step(input logic [63:0] t, input logic [63:0] x2);
    return (t * x2 + (64'd1 << 29)) >> 30;
  endfunction

  // sin(k deg) in Q30 by series, rounded to frac fraction bits
  function automatic logic [31:0] sine_entry(input int k, input int frac);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(k) * PI_Q30 + 64'(HALF_TURN / 2)) / HALF_TURN;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = signed'(x);
    term = taylor_step(term, x2) / 64'd6;   sum = sum - signed'(term);
    term = taylor_step(term, x2) / 64'd20;  sum = sum + signed'(term);
    term = taylor_step(term, x2) / 64'd42;  sum = sum - signed'(term);
    term = taylor_step(term, x2) / 64'd72;  sum = sum + signed'(term);
    term = taylor_step(term, x2) / 64'd110; sum = sum - signed'(term);
    term = taylor_step(term, x2) / 64'd156; sum = sum + signed'(term);
    term = taylor_step(term, x2) / 64'd210; sum = sum - signed'(term);
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return 32'((sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac));
  endfunction

endpackage

// ===== hw/rtl/atu_ctrl.sv =====
module atu_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [3:0]   in_func,
  input  logic         out_busy,
  output atu_pkg::cmd_t cmd
);
  import atu_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  func_t      func_r, func_nxt;
  logic       crow;
  logic [2:0] csub;
  logic       csecond;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      func_r  <= FN_TRANSLATE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      func_r  <= func_nxt;
    end
  end

  assign crow    = (step_r >= 4'd6);
  assign csub    = crow ? 3'(step_r - 4'd6) : step_r[2:0];
  assign csecond = csub[0];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    func_nxt  = func_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        step_nxt = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          func_nxt = func_t'(in_func);
          case (func_t'(in_func))
            FN_TRANSLATE, FN_ROTATE, FN_SCALE, FN_REFLECT_X, FN_REFLECT_Y,
            FN_REFLECT_YX, FN_REFLECT_YNX: state_nxt = S_COMP;
            FN_ROTATE_REF, FN_SCALE_REF, FN_SHEAR_X, FN_SHEAR_Y: state_nxt = S_BUILD;
            FN_XFORM: state_nxt = S_WAIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_BUILD: begin
        cmd.issue = 1'b1;
        step_nxt  = step_r + 4'd1;
        case (func_r)
          FN_ROTATE_REF: begin
            case (step_r[1:0])
              2'd0: begin
                cmd.a_sel = A_C; cmd.b_sel = B_CX; cmd.clr = 1'b1;
                cmd.add_sel = ADD_CX; cmd.neg = 1'b1;
              end
              2'd1: begin
                cmd.a_sel = A_S; cmd.b_sel = B_CY; cmd.wr_sel = WR_E2;
              end
              2'd2: begin
                cmd.a_sel = A_S; cmd.b_sel = B_CX; cmd.clr = 1'b1;
                cmd.add_sel = ADD_CY; cmd.neg = 1'b1;
              end
              default: begin
                cmd.a_sel = A_C; cmd.b_sel = B_CY; cmd.neg = 1'b1;
                cmd.wr_sel = WR_E5;
                state_nxt = S_COMP; step_nxt = '0;
              end
            endcase
          end
          FN_SCALE_REF: begin
            cmd.clr = 1'b1; cmd.neg = 1'b1;
            if (step_r[0]) begin
              cmd.a_sel = A_PY; cmd.b_sel = B_CY; cmd.add_sel = ADD_CY;
              cmd.wr_sel = WR_E5;
              state_nxt = S_COMP; step_nxt = '0;
            end else begin
              cmd.a_sel = A_PX; cmd.b_sel = B_CX; cmd.add_sel = ADD_CX;
              cmd.wr_sel = WR_E2;
            end
          end
          FN_SHEAR_X: begin
            cmd.a_sel = A_PX; cmd.b_sel = B_CY; cmd.clr = 1'b1; cmd.neg = 1'b1;
            cmd.wr_sel = WR_E2;
            state_nxt = S_COMP; step_nxt = '0;
          end
          default: begin
            cmd.a_sel = A_PX; cmd.b_sel = B_CX; cmd.clr = 1'b1; cmd.neg = 1'b1;
            cmd.wr_sel = WR_E5;
            state_nxt = S_COMP; step_nxt = '0;
          end
        endcase
      end
      S_COMP: begin
        cmd.issue = 1'b1;
        cmd.row   = crow;
        cmd.a_sel = csecond ? A_MB : A_MA;
        cmd.clr   = !csecond;
        case (csub[2:1])
          2'd0: begin
            cmd.b_sel  = csecond ? B_E3 : B_E0;
            cmd.wr_sel = csecond ? WR_NB0 : WR_NONE;
          end
          2'd1: begin
            cmd.b_sel  = csecond ? B_E4 : B_E1;
            cmd.wr_sel = csecond ? WR_NB1 : WR_NONE;
          end
          default: begin
            cmd.b_sel   = csecond ? B_E5 : B_E2;
            cmd.wr_sel  = csecond ? WR_ROW : WR_NONE;
            cmd.add_sel = csecond ? ADD_NONE : ADD_MT;
          end
        endcase
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd11) state_nxt = S_DRAIN1;
      end
      S_WAIT: begin
        if (!out_busy) state_nxt = S_XFORM;
      end
      S_XFORM: begin
        cmd.issue = 1'b1;
        cmd.row   = step_r[1];
        cmd.a_sel = step_r[0] ? A_MB : A_MA;
        cmd.b_sel = step_r[0] ? B_QY : B_QX;
        cmd.clr   = !step_r[0];
        cmd.add_sel = step_r[0] ? ADD_NONE : ADD_MT;
        if (step_r[0]) cmd.wr_sel = step_r[1] ? WR_OY : WR_OX;
        step_nxt = step_r + 4'd1;
        if (step_r[1:0] == 2'd3) state_nxt = S_DRAIN1;
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/atu_dp.sv =====
module atu_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  atu_pkg::cmd_t      cmd,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_param_x,
  input  logic signed [31:0] in_param_y,
  input  logic [8:0]         in_angle_deg,
  input  logic signed [15:0] in_ref_x,
  input  logic signed [15:0] in_ref_y,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               out_saturated,
  output logic               out_busy
);
  import atu_pkg::*;

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic [FRAC_BITS:0] sine_rom [SINE_DEPTH];

  for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_rom
    localparam logic [FRAC_BITS:0] V = (FRAC_BITS + 1)'(sine_entry(k, FRAC_BITS));
    assign sine_rom[k] = V;
  end

  logic signed [31:0] m_r [6];
  logic signed [31:0] e_r [6];
  logic signed [31:0] e_load [6];
  logic signed [31:0] nb_r [2];
  logic signed [31:0] px_r, py_r, qx_r, qy_r;
  logic signed [15:0] cx_r, cy_r;
  logic signed [FRAC_BITS+1:0] s_r, c_r;
  logic signed [FRAC_BITS+1:0] s_val, c_val;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] addend_r, acc_r, acc_nxt, prod_ext, rnd_sh;
  cmd_t cmd1_r, cmd2_r;
  logic signed [31:0] op_a, op_b, mt;
  logic signed [ACC_W-1:0] addend;
  sat_t ecl, rq;
  logic signed [31:0] ox_r;
  logic satx_r;
  logic out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic out_sat_r;
  logic [8:0] d9;
  logic [6:0] si, ci;
  logic sn, cn;

  // angle fold into the first quadrant
  always_comb begin
    d9 = (in_angle_deg >= 9'(FULL_TURN)) ? in_angle_deg - 9'(FULL_TURN) : in_angle_deg;
    if (d9 <= 9'(QUARTER_TURN)) begin
      si = 7'(d9); ci = 7'(9'(QUARTER_TURN) - d9); sn = 1'b0; cn = 1'b0;
    end else if (d9 <= 9'(HALF_TURN)) begin
      si = 7'(9'(HALF_TURN) - d9); ci = 7'(d9 - 9'(QUARTER_TURN)); sn = 1'b0; cn = 1'b1;
    end else if (d9 <= 9'(HALF_TURN + QUARTER_TURN)) begin
      si = 7'(d9 - 9'(HALF_TURN)); ci = 7'(9'(HALF_TURN + QUARTER_TURN) - d9);
      sn = 1'b1; cn = 1'b1;
    end else begin
      si = 7'(9'(FULL_TURN) - d9); ci = 7'(d9 - 9'(HALF_TURN + QUARTER_TURN));
      sn = 1'b1; cn = 1'b0;
    end
    s_val = sn ? -signed'({1'b0, sine_rom[si]}) : signed'({1'b0, sine_rom[si]});
    c_val = cn ? -signed'({1'b0, sine_rom[ci]}) : signed'({1'b0, sine_rom[ci]});
  end

  // elementary matrix as it stands right after the request is taken
  always_comb begin
    e_load[0] = ONE_Q; e_load[1] = '0; e_load[2] = '0;
    e_load[3] = '0;    e_load[4] = ONE_Q; e_load[5] = '0;
    case (func_t'(in_func))
      FN_TRANSLATE: begin e_load[2] = in_param_x; e_load[5] = in_param_y; end
      FN_ROTATE, FN_ROTATE_REF: begin
        e_load[0] = 32'(c_val); e_load[1] = -32'(s_val);
        e_load[3] = 32'(s_val); e_load[4] = 32'(c_val);
      end
      FN_SCALE, FN_SCALE_REF: begin e_load[0] = in_param_x; e_load[4] = in_param_y; end
      FN_REFLECT_X: e_load[4] = -ONE_Q;
      FN_REFLECT_Y: e_load[0] = -ONE_Q;
      FN_REFLECT_YX: begin
        e_load[0] = '0; e_load[4] = '0; e_load[1] = ONE_Q; e_load[3] = ONE_Q;
      end
      FN_REFLECT_YNX: begin
        e_load[0] = '0; e_load[4] = '0; e_load[1] = -ONE_Q; e_load[3] = -ONE_Q;
      end
      FN_SHEAR_X: e_load[1] = in_param_x;
      FN_SHEAR_Y: e_load[3] = in_param_x;
      default: ;
    endcase
  end

  assign mt = cmd.row ? m_r[5] : m_r[2];

  always_comb begin
    case (cmd.a_sel)
      A_C:     op_a = 32'(c_r);
      A_S:     op_a = 32'(s_r);
      A_PX:    op_a = px_r;
      A_PY:    op_a = py_r;
      A_MA:    op_a = cmd.row ? m_r[3] : m_r[0];
      A_MB:    op_a = cmd.row ? m_r[4] : m_r[1];
      default: op_a = '0;
    endcase
    case (cmd.b_sel)
      B_CX:    op_b = 32'(cx_r);
      B_CY:    op_b = 32'(cy_r);
      B_E0:    op_b = e_r[0];
      B_E1:    op_b = e_r[1];
      B_E2:    op_b = e_r[2];
      B_E3:    op_b = e_r[3];
      B_E4:    op_b = e_r[4];
      B_E5:    op_b = e_r[5];
      B_QX:    op_b = qx_r;
      B_QY:    op_b = qy_r;
      default: op_b = '0;
    endcase
    case (cmd.add_sel)
      ADD_CX:  addend = ACC_W'(cx_r) <<< FRAC_BITS;
      ADD_CY:  addend = ACC_W'(cy_r) <<< FRAC_BITS;
      ADD_MT:  addend = ACC_W'(mt) <<< FRAC_BITS;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r   <= op_a * op_b;
    addend_r <= addend;
    if (!rst_n) begin
      cmd1_r <= '0;
      cmd2_r <= '0;
    end else begin
      cmd1_r <= cmd;
      cmd2_r <= cmd1_r;
    end
  end

  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = (cmd1_r.clr ? '0 : acc_r) + (cmd1_r.neg ? -prod_ext : prod_ext) + addend_r;

  always_ff @(posedge clk) begin
    if (cmd1_r.issue) acc_r <= acc_nxt;
  end

  assign ecl    = sat32(acc_r);
  assign rnd_sh = (acc_r + RND) >>> FRAC_BITS;
  assign rq     = sat32(rnd_sh);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_param_x; py_r <= in_param_y;
      cx_r <= in_ref_x;   cy_r <= in_ref_y;
      qx_r <= in_point_x; qy_r <= in_point_y;
      s_r  <= s_val;      c_r  <= c_val;
      e_r  <= e_load;
    end else begin
      case (cmd2_r.wr_sel)
        WR_E2:  e_r[2] <= ecl.v;
        WR_E5:  e_r[5] <= ecl.v;
        WR_NB0: nb_r[0] <= rq.v;
        WR_NB1: nb_r[1] <= rq.v;
        WR_OX:  begin ox_r <= rq.v; satx_r <= rq.hit; end
        default: ;
      endcase
    end
  end

  // composite matrix: commit a whole row at once
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && func_t'(in_func) == FN_RESET)) begin
      m_r[0] <= ONE_Q; m_r[1] <= '0; m_r[2] <= '0;
      m_r[3] <= '0;    m_r[4] <= ONE_Q; m_r[5] <= '0;
    end else if (cmd2_r.wr_sel == WR_ROW) begin
      if (cmd2_r.row) begin
        m_r[3] <= nb_r[0]; m_r[4] <= nb_r[1]; m_r[5] <= rq.v;
      end else begin
        m_r[0] <= nb_r[0]; m_r[1] <= nb_r[1]; m_r[2] <= rq.v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd2_r.wr_sel == WR_OY) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd2_r.wr_sel == WR_OY) begin
      out_x_r   <= ox_r;
      out_y_r   <= rq.v;
      out_sat_r <= satx_r | rq.hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_saturated = out_sat_r;
  assign out_busy      = out_valid_r;

endmodule

// ===== hw/rtl/affine_transform_2d_unit.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_func, in_param_x/y, in_angle_deg, in_ref_x/y, in_point_x/y
// out       out_valid / out_ready   out_x, out_y, out_saturated
//
// One request at a time through a single shared 32x32 multiplier, one product per cycle,
// plus the drain states S_DRAIN1 and S_DRAIN2 to empty the multiply/accumulate pipe.
// Steps per request: reset and unused codes finish in idle; translate, rotate, scale, reflect
// compose; shear, scale about point, rotate about point build first, then compose; transform
// waits for the previous result to be taken, then computes.
// Synchronous active-low reset; composite matrix returns to identity.
// A pending result does not block new requests; only a transform waits for the output slot.
module affine_transform_2d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_param_x,
  input  logic signed [31:0] in_param_y,
  input  logic [8:0]         in_angle_deg,
  input  logic signed [15:0] in_ref_x,
  input  logic signed [15:0] in_ref_y,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               out_saturated
);
  import atu_pkg::*;

  cmd_t cmd;
  logic out_busy;

  // sequencer: walks build, compose and transform product lists
  atu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  // datapath: operand latches, sine table, multiplier, accumulator, matrix, output slot
  atu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_func       (in_func),
    .in_param_x    (in_param_x),
    .in_param_y    (in_param_y),
    .in_angle_deg  (in_angle_deg),
    .in_ref_x      (in_ref_x),
    .in_ref_y      (in_ref_y),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_saturated (out_saturated),
    .out_busy      (out_busy)
  );

endmodule

// ===== hw/rtl/atu_checker.sv =====
module atu_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [3:0]        in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic              out_saturated
);
  import atu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
       out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000))
    else $error("saturated flag without a clipped coordinate");

  a_busy_after_xform: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FN_XFORM || in_func == FN_TRANSLATE) |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while unit was idle");

endmodule

bind affine_transform_2d_unit atu_checker u_chk (.*);
